@@ sv/skt_pkg.sv @@
// Shared types, codes and defaults of the sorted key table.
package skt_pkg;

  // Default table geometry.
  localparam int DEF_CAPACITY  = 64;
  localparam int DEF_KEY_WIDTH = 32;

  // Request kinds.
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_FIND   = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // Configuration register index, taken from paddr[2].
  localparam logic REG_SIGNED_ORDER = 1'b0;
  localparam int   PADDR_W          = 3;

  // One request transaction.
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [5:0]  index;
  } req_t;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  position;
    logic [31:0] entry;
    logic [6:0]  count;
  } rsp_t;

  // Outcome of the shared key comparator.
  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_res_t;

endpackage

@@ sv/skt_store.sv @@
// Key storage: one write port and one registered read port.
module skt_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/skt_cmp.sv @@
// Shared key comparator for unsigned or two's complement order.
module skt_cmp
  import skt_pkg::cmp_res_t;
#(
  parameter int KEY_WIDTH = 32
) (
  input  logic [KEY_WIDTH-1:0] have,
  input  logic [KEY_WIDTH-1:0] want,
  input  logic                 signed_order,
  output cmp_res_t             res
);

  logic [KEY_WIDTH-1:0] flip;
  logic [KEY_WIDTH-1:0] have_ord;
  logic [KEY_WIDTH-1:0] want_ord;

  // Flipping the sign bit turns two's complement order into unsigned order.
  always_comb begin
    flip = '0;
    flip[KEY_WIDTH-1] = signed_order;
    have_ord = have ^ flip;
    want_ord = want ^ flip;
    res.lt = have_ord < want_ord;
    res.gt = have_ord > want_ord;
  end

endmodule

@@ sv/skt_seq.sv @@
// Sequencer: binary search, shift-up insert, indexed read and clear.
module skt_seq
  import skt_pkg::req_t;
  import skt_pkg::rsp_t;
  import skt_pkg::cmp_res_t;
#(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32,
  parameter int AW        = 6,
  parameter int CW        = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  input  logic [KEY_WIDTH-1:0] rd_data,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [KEY_WIDTH-1:0] wr_data,
  output logic [KEY_WIDTH-1:0] want,
  input  cmp_res_t             cmp
);
  import skt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_CMP    = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_MOVE   = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam int IXW = (CW > 6) ? CW : 6;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [2:0]           state, state_next;
  logic [1:0]           mode, mode_next;
  logic [KEY_WIDTH-1:0] key, key_next;
  logic [CW-1:0]        occ, occ_next;
  logic [CW-1:0]        lo, lo_next;
  logic [CW-1:0]        hi, hi_next;
  logic [CW-1:0]        mid, mid_next;
  logic [CW-1:0]        ptr, ptr_next;
  logic [1:0]           res_status, res_status_next;
  logic [CW-1:0]        res_pos, res_pos_next;
  logic [KEY_WIDTH-1:0] res_entry, res_entry_next;
  logic                 rsp_valid_next;
  rsp_t                 rsp_next;
  logic [CW-1:0]        mid_calc;
  logic                 idx_in_range;

  assign req_stall = (state != S_IDLE);
  assign want      = key;
  assign mid_calc  = lo + ((hi - lo) >> 1);
  assign idx_in_range = IXW'(req.index) < IXW'(occ);

  // Next-state and datapath control.
  always_comb begin
    state_next      = state;
    mode_next       = mode;
    key_next        = key;
    occ_next        = occ;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    ptr_next        = ptr;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    res_entry_next  = res_entry;
    rsp_valid_next  = rsp_valid && rsp_stall;
    rsp_next        = rsp;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = rd_data;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          mode_next       = req.mode;
          key_next        = KEY_WIDTH'(req.key);
          lo_next         = '0;
          hi_next         = occ;
          res_status_next = ST_OK;
          res_pos_next    = '0;
          res_entry_next  = '0;
          unique case (req.mode)
            MODE_INSERT, MODE_FIND: begin
              state_next = S_SEARCH;
            end
            MODE_READ: begin
              if (idx_in_range) begin
                rd_en      = 1'b1;
                rd_addr    = AW'(req.index);
                state_next = S_READ;
              end else begin
                res_status_next = ST_MISS;
                state_next      = S_DONE;
              end
            end
            default: begin
              occ_next   = '0;
              state_next = S_DONE;
            end
          endcase
        end
      end

      // Probe the middle of the open range; once it is empty, settle on a miss or a full table, or start the insert.
      S_SEARCH: begin
        if (lo < hi) begin
          rd_en      = 1'b1;
          rd_addr    = mid_calc[AW-1:0];
          mid_next   = mid_calc;
          state_next = S_CMP;
        end else if (mode == MODE_FIND) begin
          res_status_next = ST_MISS;
          state_next      = S_DONE;
        end else if (occ >= CAP_CNT) begin
          res_status_next = ST_FULL;
          state_next      = S_DONE;
        end else begin
          ptr_next   = occ;
          state_next = S_SHIFT;
        end
      end

      // Narrow the range from the comparator outcome, or settle on a match.
      S_CMP: begin
        if (cmp.lt) begin
          lo_next    = mid + 1'b1;
          state_next = S_SEARCH;
        end else if (cmp.gt) begin
          hi_next    = mid;
          state_next = S_SEARCH;
        end else begin
          res_status_next = (mode == MODE_INSERT) ? ST_DUP : ST_OK;
          res_pos_next    = mid;
          state_next      = S_DONE;
        end
      end

      // Move entries above the insert point up one slot, top first, then write the key there.
      S_SHIFT: begin
        if (ptr > lo) begin
          rd_en      = 1'b1;
          rd_addr    = AW'(ptr - 1'b1);
          state_next = S_MOVE;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = lo[AW-1:0];
          wr_data      = key;
          occ_next     = occ + 1'b1;
          res_pos_next = lo;
          state_next   = S_DONE;
        end
      end

      S_MOVE: begin
        wr_en      = 1'b1;
        wr_addr    = ptr[AW-1:0];
        wr_data    = rd_data;
        ptr_next   = ptr - 1'b1;
        state_next = S_SHIFT;
      end

      S_READ: begin
        res_entry_next = rd_data;
        state_next     = S_DONE;
      end

      // Hand the result over once the output register is free.
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next    = 1'b1;
          rsp_next.status   = res_status;
          rsp_next.position = 6'(res_pos);
          rsp_next.entry    = 32'(res_entry);
          rsp_next.count    = 7'(occ);
          state_next        = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Working registers and the output register.
  always_ff @(posedge clk) begin
    mode       <= mode_next;
    key        <= key_next;
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    ptr        <= ptr_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    res_entry  <= res_entry_next;
    rsp        <= rsp_next;
  end

endmodule

@@ sv/sorted_key_table.sv @@
// Top level of the sorted key table: configuration register and submodules.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  skt_pkg::req_t
//   rsp       out         rsp_valid / rsp_stall  skt_pkg::rsp_t
//   apb       in          psel / penable         signed_order at byte address 0
//
// A clear settles at once, and a read by index reads the key store, then reports.
// A find or insert runs a binary search of at most ceil(log2(count + 1)) probes;
// an insert then shifts the entries above its slot up, top first, and writes the key.
// The single read port of the key store and the one comparator make each probe and move a step of its own.
// Reset is synchronous and active high; it empties the table and sets unsigned order.
// The block takes a new request only while idle; a stalled result holds in the
// output register, and the next request may run until its result is ready.
module sorted_key_table #(
  parameter int CAPACITY  = skt_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = skt_pkg::DEF_KEY_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  skt_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output skt_pkg::rsp_t               rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [skt_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import skt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                 signed_order;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [KEY_WIDTH-1:0] rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  logic [KEY_WIDTH-1:0] want;
  cmp_res_t             cmp;

  // Configuration register, written in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      signed_order <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SIGNED_ORDER) begin
      signed_order <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SIGNED_ORDER) ? {31'd0, signed_order} : 32'd0;

  skt_store #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_WIDTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  skt_cmp #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_cmp (
    .have         (rd_data),
    .want         (want),
    .signed_order (signed_order),
    .res          (cmp)
  );

  skt_seq #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH),
    .AW        (AW),
    .CW        (CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .want      (want),
    .cmp       (cmp)
  );

endmodule

@@ sv/skt_check.sv @@
// Port-level checks of the sorted key table and their binding.
module skt_check
  import skt_pkg::req_t;
  import skt_pkg::rsp_t;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);
  import skt_pkg::*;

  // A stalled result transaction holds its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // No request completes while it is being accepted, so the block is busy right after one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while busy");

  // A full-table result carries no position and no entry.
  a_full_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.position == 6'd0 && rsp.entry == 32'd0)
    else $error("full result carries data");

  // A miss carries no position.
  a_miss_position: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_MISS |-> rsp.position == 6'd0)
    else $error("miss result carries a position");

endmodule

bind sorted_key_table skt_check u_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
